// ===== sv/fat12te_pkg.sv =====
// Shared constants, state type and entry helpers for the FAT12 table engine.
`default_nettype none
package fat12te_pkg;

	localparam int ENTRY_COUNT_DEF = 3072;
	localparam int TABLE_BYTES_DEF = 4608;

	localparam logic [2:0] CMD_READ   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_FIND   = 3'd2;
	localparam logic [2:0] CMD_FOLLOW = 3'd3;
	localparam logic [2:0] CMD_LOAD   = 3'd4;
	localparam logic [2:0] CMD_DUMP   = 3'd5;

	localparam logic [2:0] KIND_NEXT     = 3'd0;
	localparam logic [2:0] KIND_EOC      = 3'd1;
	localparam logic [2:0] KIND_BAD      = 3'd2;
	localparam logic [2:0] KIND_FREE     = 3'd3;
	localparam logic [2:0] KIND_RESERVED = 3'd4;

	localparam logic [11:0] LINK_RSV_LO = 12'hFF0;
	localparam logic [11:0] LINK_RSV_HI = 12'hFF6;
	localparam logic [11:0] LINK_BAD    = 12'hFF7;
	localparam logic [11:0] LINK_EOC_LO = 12'hFF8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_LO,
		ST_RD_HI,
		ST_EVAL,
		ST_WR_HI,
		ST_BYTE,
		ST_BYTE_RD,
		ST_DONE
	} state_t;

	// Classification order matters: reserved and bad codes are checked before end of chain.
	function automatic logic [2:0] classify(input logic [11:0] v);
		logic [2:0] k;
		if (v >= LINK_RSV_LO && v <= LINK_RSV_HI) begin
			k = KIND_RESERVED;
		end else if (v == LINK_BAD) begin
			k = KIND_BAD;
		end else if (v == 12'h000) begin
			k = KIND_FREE;
		end else if (v >= LINK_EOC_LO) begin
			k = KIND_EOC;
		end else begin
			k = KIND_NEXT;
		end
		return k;
	endfunction

	// Even entries take the whole low byte and the low nibble of the high byte;
	// odd entries take the high nibble of the low byte and the whole high byte.
	function automatic logic [11:0] entry_join(input logic odd, input logic [7:0] lo,
			input logic [7:0] hi);
		logic [11:0] v;
		if (odd) begin
			v = {hi, lo[7:4]};
		end else begin
			v = {hi[3:0], lo};
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/fat12_table_engine_unit.sv =====
// FAT12 allocation table engine: top level with command sequencer and result register.
`default_nettype none
// The table lives in a single-port byte memory with a registered read; an entry spans two
// bytes, so every entry access is two reads on that port. Each command gives one result
// word. Read entry and follow link read the low and high bytes and then evaluate; write
// entry does the same two reads, then two writes; load writes one byte, dump reads one,
// and an unknown command goes straight to the result. Find free walks entries from the
// start index, reading and evaluating each, until it meets a free entry or the last one.
// A new command is taken in the cycle after the previous one has placed its result in
// the output register, even while that result still waits for the sink; no command is
// taken while another is in progress.
// The memory is not cleared: bytes must be loaded before they are read.
module fat12_table_engine_unit #(
	parameter int ENTRY_COUNT = fat12te_pkg::ENTRY_COUNT_DEF,
	parameter int TABLE_BYTES = fat12te_pkg::TABLE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// entry_index[11:0], new_value[23:12], byte_addr[36:24], byte_in[44:37], zero fill
	input  wire logic [47:0] s_tdata,
	// cmd[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// entry_value[11:0], free_index[23:12], byte_out[31:24]
	output logic      [31:0] m_tdata,
	// link_kind[2:0]
	output logic      [2:0]  m_tuser
);

	localparam int MEM_AW = $clog2(TABLE_BYTES);

	fat12te_pkg::state_t state_q, state_d;

	logic [2:0]  cmd_q;
	logic [11:0] cur_q;
	logic [11:0] nv_q;
	logic [12:0] addr_q;
	logic [7:0]  bin_q;
	logic [7:0]  lo_q;
	logic [7:0]  hi_new_q;

	logic [11:0] res_ev_q;
	logic [11:0] res_fi_q;
	logic [2:0]  res_kind_q;
	logic [7:0]  res_bout_q;

	logic        out_valid_q;
	logic [11:0] out_ev_q;
	logic [11:0] out_fi_q;
	logic [2:0]  out_kind_q;
	logic [7:0]  out_bout_q;

	logic              mem_re;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_addr;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;

	logic        in_accept;
	logic        out_load;
	logic [13:0] off;
	logic [13:0] off_hi;
	logic        lo_ok;
	logic        hi_ok;
	logic        idx_ok;
	logic        byte_ok;
	logic        last_entry;
	logic [7:0]  hi_byte;
	logic [11:0] entry_val;
	logic [7:0]  wr_lo;
	logic [7:0]  wr_hi;

	fat12te_ram #(
		.DEPTH(TABLE_BYTES),
		.AW   (MEM_AW)
	) u_ram (
		.clk  (clk),
		.re   (mem_re),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Entry i starts at byte i + i/2.
	assign off        = {2'b00, cur_q} + {3'b000, cur_q[11:1]};
	assign off_hi     = off + 14'd1;
	assign lo_ok      = off < 14'(TABLE_BYTES);
	assign hi_ok      = off_hi < 14'(TABLE_BYTES);
	assign idx_ok     = cur_q < 12'(ENTRY_COUNT);
	assign byte_ok    = {1'b0, addr_q} < 14'(TABLE_BYTES);
	assign last_entry = ({1'b0, cur_q} + 13'd1) >= 13'(ENTRY_COUNT);
	assign hi_byte    = hi_ok ? mem_rdata : 8'h00;
	assign entry_val  = fat12te_pkg::entry_join(cur_q[0], lo_q, hi_byte);
	assign wr_lo      = cur_q[0] ? {nv_q[3:0], lo_q[3:0]} : nv_q[7:0];
	assign wr_hi      = cur_q[0] ? nv_q[11:4] : {hi_byte[7:4], nv_q[11:8]};
	assign in_accept  = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fat12te_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser) inside
						fat12te_pkg::CMD_READ, fat12te_pkg::CMD_WRITE,
						fat12te_pkg::CMD_FIND, fat12te_pkg::CMD_FOLLOW: begin
							state_d = fat12te_pkg::ST_RD_LO;
						end
						fat12te_pkg::CMD_LOAD, fat12te_pkg::CMD_DUMP: begin
							state_d = fat12te_pkg::ST_BYTE;
						end
						default: begin
							state_d = fat12te_pkg::ST_DONE;
						end
					endcase
				end
			end
			fat12te_pkg::ST_RD_LO: begin
				state_d = idx_ok ? fat12te_pkg::ST_RD_HI : fat12te_pkg::ST_DONE;
			end
			fat12te_pkg::ST_RD_HI: begin
				state_d = fat12te_pkg::ST_EVAL;
			end
			fat12te_pkg::ST_EVAL: begin
				if (cmd_q == fat12te_pkg::CMD_WRITE) begin
					state_d = fat12te_pkg::ST_WR_HI;
				end else if (cmd_q == fat12te_pkg::CMD_FIND && entry_val != 12'h000
						&& !last_entry) begin
					state_d = fat12te_pkg::ST_RD_LO;
				end else begin
					state_d = fat12te_pkg::ST_DONE;
				end
			end
			fat12te_pkg::ST_WR_HI: begin
				state_d = fat12te_pkg::ST_DONE;
			end
			fat12te_pkg::ST_BYTE: begin
				state_d = (cmd_q == fat12te_pkg::CMD_DUMP) ? fat12te_pkg::ST_BYTE_RD
						: fat12te_pkg::ST_DONE;
			end
			fat12te_pkg::ST_BYTE_RD: begin
				state_d = fat12te_pkg::ST_DONE;
			end
			fat12te_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = fat12te_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fat12te_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		out_load  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = off[MEM_AW-1:0];
		mem_wdata = wr_lo;
		unique case (state_q)
			fat12te_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			fat12te_pkg::ST_RD_LO: begin
				mem_re = idx_ok && lo_ok;
			end
			fat12te_pkg::ST_RD_HI: begin
				mem_re   = hi_ok;
				mem_addr = off_hi[MEM_AW-1:0];
			end
			fat12te_pkg::ST_EVAL: begin
				mem_we = (cmd_q == fat12te_pkg::CMD_WRITE) && lo_ok;
			end
			fat12te_pkg::ST_WR_HI: begin
				mem_we    = hi_ok;
				mem_addr  = off_hi[MEM_AW-1:0];
				mem_wdata = hi_new_q;
			end
			fat12te_pkg::ST_BYTE: begin
				mem_re    = (cmd_q == fat12te_pkg::CMD_DUMP) && byte_ok;
				mem_we    = (cmd_q == fat12te_pkg::CMD_LOAD) && byte_ok;
				mem_addr  = addr_q[MEM_AW-1:0];
				mem_wdata = bin_q;
			end
			fat12te_pkg::ST_BYTE_RD: begin
				mem_addr = addr_q[MEM_AW-1:0];
			end
			fat12te_pkg::ST_DONE: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fat12te_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q      <= s_tuser;
			cur_q      <= s_tdata[11:0];
			nv_q       <= s_tdata[23:12];
			addr_q     <= s_tdata[36:24];
			bin_q      <= s_tdata[44:37];
			res_ev_q   <= 12'h000;
			res_fi_q   <= 12'h000;
			res_kind_q <= fat12te_pkg::KIND_NEXT;
			res_bout_q <= 8'h00;
		end
		// An entry beyond the table reads as zero, so a follow on it reports free.
		if (state_q == fat12te_pkg::ST_RD_LO && !idx_ok && cmd_q == fat12te_pkg::CMD_FOLLOW) begin
			res_kind_q <= fat12te_pkg::KIND_FREE;
		end
		if (state_q == fat12te_pkg::ST_RD_HI) begin
			lo_q <= lo_ok ? mem_rdata : 8'h00;
		end
		if (state_q == fat12te_pkg::ST_EVAL) begin
			hi_new_q <= wr_hi;
			case (cmd_q)
				fat12te_pkg::CMD_READ: begin
					res_ev_q <= entry_val;
				end
				fat12te_pkg::CMD_FOLLOW: begin
					res_ev_q   <= entry_val;
					res_kind_q <= fat12te_pkg::classify(entry_val);
				end
				fat12te_pkg::CMD_FIND: begin
					if (entry_val == 12'h000) begin
						res_fi_q <= cur_q;
					end else begin
						cur_q <= cur_q + 12'd1;
					end
				end
				default: begin
					res_ev_q <= res_ev_q;
				end
			endcase
		end
		if (state_q == fat12te_pkg::ST_BYTE_RD) begin
			res_bout_q <= byte_ok ? mem_rdata : 8'h00;
		end
		if (out_load) begin
			out_ev_q   <= res_ev_q;
			out_fi_q   <= res_fi_q;
			out_kind_q <= res_kind_q;
			out_bout_q <= res_bout_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_bout_q, out_fi_q, out_ev_q};
	assign m_tuser  = out_kind_q;

endmodule
`default_nettype wire

// ===== sv/fat12te_ram.sv =====
// Single-port table byte store with a registered read.
`default_nettype none
module fat12te_ram #(
	parameter int DEPTH = fat12te_pkg::TABLE_BYTES_DEF,
	parameter int AW    = $clog2(fat12te_pkg::TABLE_BYTES_DEF)
) (
	input  wire logic          clk,
	input  wire logic          re,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ===== bench/fat12_table_engine_unit_tb.sv =====
// Self-checking stream testbench for the FAT12 table engine with a scoreboard class.
`timescale 1ns / 1ps
module fat12_table_engine_unit_tb;

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int RANDOM_WORDS = 420;
	localparam int STALL_LIMIT = 50000;
	localparam int HOLD_CYCLES = 400;
	// Only a low window and the last sixteen entries are loaded. The last low entry stays
	// free, so no search ever walks into bytes that were never written.
	localparam int LOW_ENTRIES = 256;
	localparam int LOW_BYTES = LOW_ENTRIES * 3 / 2;
	localparam int HIGH_FIRST = fat12te_pkg::ENTRY_COUNT_DEF - 16;
	localparam int HIGH_BYTE = HIGH_FIRST * 3 / 2;

	typedef struct packed {
		logic [11:0] entry_value;
		logic [11:0] free_index;
		logic [2:0]  link_kind;
		logic [7:0]  byte_out;
	} fat_reply_t;

	class fat12_table_sb;
		logic [7:0] shadow [fat12te_pkg::TABLE_BYTES_DEF];
		fat_reply_t awaited_replies [$];
		int errors;
		int replies_checked;
		int cmd_count [8];
		int kind_count [5];
		int longest_search;
		logic [11:0] last_entry;
		logic [11:0] last_free;
		logic [2:0] last_kind;

		function logic [7:0] table_byte(int addr);
			if (addr >= fat12te_pkg::TABLE_BYTES_DEF) return 8'h00;
			return shadow[addr];
		endfunction

		function logic [11:0] table_entry(int idx);
			int off;
			logic [7:0] lo, hi;
			if (idx >= fat12te_pkg::ENTRY_COUNT_DEF) return 12'h000;
			off = (idx * 3) / 2;
			lo = table_byte(off);
			hi = table_byte(off + 1);
			if (idx % 2) return {hi, lo[7:4]};
			return {hi[3:0], lo};
		endfunction

		function void store_entry(int idx, logic [11:0] v);
			int off;
			if (idx >= fat12te_pkg::ENTRY_COUNT_DEF) return;
			off = (idx * 3) / 2;
			// The nibble shared with the neighbouring entry must survive the write.
			if (idx % 2) begin
				shadow[off] = {v[3:0], shadow[off][3:0]};
				shadow[off + 1] = v[11:4];
			end else begin
				shadow[off] = v[7:0];
				shadow[off + 1] = {shadow[off + 1][7:4], v[11:8]};
			end
		endfunction

		function logic [2:0] kind_of_link(logic [11:0] v);
			if (v >= fat12te_pkg::LINK_RSV_LO && v <= fat12te_pkg::LINK_RSV_HI)
				return fat12te_pkg::KIND_RESERVED;
			if (v == fat12te_pkg::LINK_BAD) return fat12te_pkg::KIND_BAD;
			if (v == 12'h000) return fat12te_pkg::KIND_FREE;
			if (v >= fat12te_pkg::LINK_EOC_LO) return fat12te_pkg::KIND_EOC;
			return fat12te_pkg::KIND_NEXT;
		endfunction

		function void note_command(logic [2:0] cmd, logic [11:0] idx, logic [11:0] nv,
				logic [12:0] addr, logic [7:0] bin);
			fat_reply_t r;
			int i;
			r = '0;
			cmd_count[cmd]++;
			case (cmd)
				fat12te_pkg::CMD_READ: begin
					r.entry_value = table_entry(idx);
					last_entry = r.entry_value;
				end
				fat12te_pkg::CMD_WRITE: store_entry(idx, nv);
				fat12te_pkg::CMD_FIND: begin
					for (i = idx; i < fat12te_pkg::ENTRY_COUNT_DEF; i++) begin
						if (table_entry(i) == 12'h000) begin
							r.free_index = i[11:0];
							break;
						end
					end
					if (i - int'(idx) > longest_search) longest_search = i - int'(idx);
					last_free = r.free_index;
				end
				fat12te_pkg::CMD_FOLLOW: begin
					r.entry_value = table_entry(idx);
					r.link_kind = kind_of_link(r.entry_value);
					kind_count[r.link_kind]++;
					last_entry = r.entry_value;
					last_kind = r.link_kind;
				end
				fat12te_pkg::CMD_LOAD: if (addr < fat12te_pkg::TABLE_BYTES_DEF) shadow[addr] = bin;
				fat12te_pkg::CMD_DUMP: r.byte_out = table_byte(addr);
				default: ;
			endcase
			awaited_replies.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_reply(logic [31:0] data, logic [2:0] user);
			fat_reply_t want;
			if (awaited_replies.size() == 0) begin
				report($sformatf("result word %h kind %0d with nothing pending", data, user));
				return;
			end
			want = awaited_replies.pop_front();
			replies_checked++;
			if (data[11:0] !== want.entry_value)
				report($sformatf("entry_value %h, want %h", data[11:0], want.entry_value));
			if (data[23:12] !== want.free_index)
				report($sformatf("free_index %h, want %h", data[23:12], want.free_index));
			if (data[31:24] !== want.byte_out)
				report($sformatf("byte_out %h, want %h", data[31:24], want.byte_out));
			if (user !== want.link_kind)
				report($sformatf("link_kind %0d, want %0d", user, want.link_kind));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0] m_tuser;

	fat12_table_sb sb;
	int snd_idle_pct = 20;
	int rcv_idle_pct = 51;
	bit pressure_armed = 1'b0;
	bit pressure_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int words_sent = 0;
	logic [7:0] fill_image [fat12te_pkg::TABLE_BYTES_DEF];

	fat12_table_engine_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Entries are taken from the loaded windows, or past the table; the free entry that
	// closes the low window is never chosen.
	function automatic logic [11:0] pick_entry();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 12'($urandom_range(fat12te_pkg::ENTRY_COUNT_DEF, 4095));
		if (r == 1) return 12'($urandom_range(HIGH_FIRST, fat12te_pkg::ENTRY_COUNT_DEF - 1));
		return 12'($urandom_range(LOW_ENTRIES - 2));
	endfunction

	// Byte addresses stay clear of the two bytes that hold the closing free entry.
	function automatic logic [12:0] pick_addr();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 13'($urandom_range(fat12te_pkg::TABLE_BYTES_DEF, 8191));
		if (r == 1) return 13'($urandom_range(HIGH_BYTE, fat12te_pkg::TABLE_BYTES_DEF - 1));
		return 13'($urandom_range(LOW_BYTES - 3));
	endfunction

	task automatic issue_cmd(logic [2:0] cmd, logic [11:0] idx, logic [11:0] nv,
			logic [12:0] addr, logic [7:0] bin);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, bin, addr, nv, idx};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(cmd, idx, nv, addr, bin);
		words_sent++;
	endtask

	// Result side: check each accepted word, then choose the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_reply(m_tdata, m_tuser);
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (pressure_armed && !pressure_done) begin
			pressure_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [11:0] link_codes [5];
		logic [11:0] chain [7];
		logic [11:0] v;
		logic [11:0] cur;
		logic [12:0] a;
		int off, len, steps, pick, base;
		link_codes = '{fat12te_pkg::LINK_RSV_LO, fat12te_pkg::LINK_RSV_HI,
			fat12te_pkg::LINK_BAD, fat12te_pkg::LINK_EOC_LO, 12'hFFF};
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The memory powers up undefined, so both windows are loaded first. Roughly half
		// the entries are free, which keeps free searches short.
		for (int i = 0; i < fat12te_pkg::ENTRY_COUNT_DEF; i++) begin
			if (i >= LOW_ENTRIES && i < HIGH_FIRST) continue;
			pick = $urandom_range(99);
			if (pick < 45 || i == LOW_ENTRIES - 1) v = 12'h000;
			else if (pick < 60) v = 12'($urandom_range(12'hFF0, 12'hFFF));
			else v = 12'($urandom_range(1, 12'hFEF));
			off = (i * 3) / 2;
			if (i % 2) begin
				fill_image[off][7:4] = v[3:0];
				fill_image[off + 1] = v[11:4];
			end else begin
				fill_image[off] = v[7:0];
				fill_image[off + 1][3:0] = v[11:8];
			end
		end
		for (int i = 0; i < fat12te_pkg::TABLE_BYTES_DEF; i++) begin
			if (i >= LOW_BYTES && i < HIGH_BYTE) continue;
			issue_cmd(fat12te_pkg::CMD_LOAD, '0, '0, 13'(i), fill_image[i]);
		end

		// Raw bytes at the table end and past it.
		issue_cmd(fat12te_pkg::CMD_LOAD, '0, '0, 13'(fat12te_pkg::TABLE_BYTES_DEF - 1), 8'hFF);
		issue_cmd(fat12te_pkg::CMD_DUMP, '0, '0, 13'(fat12te_pkg::TABLE_BYTES_DEF - 1), '0);
		issue_cmd(fat12te_pkg::CMD_LOAD, 12'hFFF, 12'hFFF, 13'h1FFF, 8'h00);
		issue_cmd(fat12te_pkg::CMD_DUMP, '0, '0, 13'h1FFF, '0);
		issue_cmd(fat12te_pkg::CMD_DUMP, '0, '0, 13'(fat12te_pkg::TABLE_BYTES_DEF), '0);
		// Neighbouring entries sharing a byte, and entries past the table.
		issue_cmd(fat12te_pkg::CMD_WRITE, 12'd0, 12'hFFF, '0, '0);
		issue_cmd(fat12te_pkg::CMD_WRITE, 12'd1, 12'h000, '0, '0);
		issue_cmd(fat12te_pkg::CMD_READ, 12'd0, '0, '0, '0);
		issue_cmd(fat12te_pkg::CMD_READ, 12'd1, '0, '0, '0);
		issue_cmd(fat12te_pkg::CMD_WRITE, 12'hFFF, 12'h5A5, '0, '0);
		issue_cmd(fat12te_pkg::CMD_READ, 12'hFFF, '0, '0, '0);
		issue_cmd(fat12te_pkg::CMD_FOLLOW, 12'(fat12te_pkg::ENTRY_COUNT_DEF), '0, '0, '0);
		// Boundaries of the reserved, bad and end-of-chain link classes.
		for (int k = 0; k < 5; k++) begin
			issue_cmd(fat12te_pkg::CMD_WRITE, 12'(k + 2), link_codes[k], '0, '0);
			issue_cmd(fat12te_pkg::CMD_FOLLOW, 12'(k + 2), '0, '0, '0);
		end
		// A search that runs off the end, one that starts past it, and one that hits.
		for (int k = 0; k < 4; k++)
			issue_cmd(fat12te_pkg::CMD_WRITE, 12'(fat12te_pkg::ENTRY_COUNT_DEF - 4 + k),
				12'(12'h801 + k), '0, '0);
		issue_cmd(fat12te_pkg::CMD_FIND, 12'(fat12te_pkg::ENTRY_COUNT_DEF - 4), '0, '0, '0);
		issue_cmd(fat12te_pkg::CMD_FIND, 12'hFFF, '0, '0, '0);
		issue_cmd(fat12te_pkg::CMD_FIND, 12'd0, '0, '0, '0);
		issue_cmd(CMD_SPARE_A, 12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF);
		issue_cmd(CMD_SPARE_B, '0, '0, '0, '0);

		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			if (words_sent - base >= 2 * RANDOM_WORDS / 3) begin
				snd_idle_pct = 0;
				rcv_idle_pct <= 0;
				pressure_armed <= 1'b1;
			end else if (words_sent - base >= RANDOM_WORDS / 3) begin
				snd_idle_pct = 51;
				rcv_idle_pct <= 20;
			end
			pick = $urandom_range(99);
			if (pick < 25) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					chain[k] = 12'($urandom_range(1, LOW_ENTRIES - 2));
				chain[len] = 12'($urandom_range(fat12te_pkg::LINK_EOC_LO, 12'hFFF));
				for (int k = 0; k < len; k++)
					issue_cmd(fat12te_pkg::CMD_WRITE, chain[k], chain[k + 1], '0, '0);
				// Walk the chain one link at a time, taking each next cluster from the scoreboard's prediction.
				cur = chain[0];
				steps = 0;
				do begin
					issue_cmd(fat12te_pkg::CMD_FOLLOW, cur, '0, '0, '0);
					cur = sb.last_entry;
					steps++;
				end while (sb.last_kind == fat12te_pkg::KIND_NEXT && steps < 8);
			end else if (pick < 45) begin
				issue_cmd(fat12te_pkg::CMD_FIND, pick_entry(), '0, '0, '0);
				if (sb.last_free != 12'h000 && sb.last_free != 12'(LOW_ENTRIES - 1)) begin
					issue_cmd(fat12te_pkg::CMD_WRITE, sb.last_free,
						12'($urandom_range(1, 12'hFFF)), '0, '0);
					issue_cmd(fat12te_pkg::CMD_READ, sb.last_free, '0, '0, '0);
				end
			end else if (pick < 60) begin
				cur = pick_entry();
				v = ($urandom_range(4) == 0) ? 12'h000 : 12'($urandom);
				issue_cmd(fat12te_pkg::CMD_WRITE, cur, v, '0, '0);
				issue_cmd(fat12te_pkg::CMD_READ, cur ^ 12'd1, '0, '0, '0);
				issue_cmd(fat12te_pkg::CMD_READ, cur, '0, '0, '0);
			end else if (pick < 75) begin
				a = pick_addr();
				issue_cmd(fat12te_pkg::CMD_LOAD, '0, '0, a, 8'($urandom));
				issue_cmd(fat12te_pkg::CMD_DUMP, '0, '0, a, '0);
				issue_cmd(fat12te_pkg::CMD_DUMP, '0, '0, a ^ 13'd1, '0);
			end else begin
				issue_cmd(3'($urandom_range(7)), pick_entry(), 12'($urandom), pick_addr(),
					8'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		while (sb.awaited_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d words: read %0d, write %0d, find %0d, follow %0d,",
			sb.replies_checked, sb.cmd_count[fat12te_pkg::CMD_READ],
			sb.cmd_count[fat12te_pkg::CMD_WRITE], sb.cmd_count[fat12te_pkg::CMD_FIND],
			sb.cmd_count[fat12te_pkg::CMD_FOLLOW]);
		$display("  load %0d, dump %0d, unused codes %0d; longest search %0d entries.",
			sb.cmd_count[fat12te_pkg::CMD_LOAD], sb.cmd_count[fat12te_pkg::CMD_DUMP],
			sb.cmd_count[CMD_SPARE_A] + sb.cmd_count[CMD_SPARE_B], sb.longest_search);
		$display("Links followed: next %0d, end %0d, bad %0d, free %0d, reserved %0d.",
			sb.kind_count[fat12te_pkg::KIND_NEXT], sb.kind_count[fat12te_pkg::KIND_EOC],
			sb.kind_count[fat12te_pkg::KIND_BAD], sb.kind_count[fat12te_pkg::KIND_FREE],
			sb.kind_count[fat12te_pkg::KIND_RESERVED]);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
